// ----- rtl/lpw_pkg.sv -----
// Shared types and codes for the lattice particle walk block.
// Used by lattice_particle_walk_step; no dependencies.
`default_nettype none
package lpw_pkg;

    // Fixed field widths of the command and result words.
    localparam int XW  = 6;
    localparam int YW  = 5;
    localparam int ZW  = 5;
    localparam int TW  = 2;
    localparam int DW  = 3;
    localparam int SW  = 3;
    // Signed working width for coordinates and capsule distances.
    localparam int CW  = 12;

    // One grid cell as stored in memory.
    typedef struct packed {
        logic          occ;
        logic          mob;
        logic [TW-1:0] typ;
    } t_cell;

    typedef enum logic [SW-1:0] {
        ST_MOVED      = 3'd0,
        ST_EDGE_BLOCK = 3'd1,
        ST_PART_BLOCK = 3'd2,
        ST_REACTED    = 3'd3,
        ST_PLACED     = 3'd4,
        ST_REJECTED   = 3'd5,
        ST_EMPTY      = 3'd6,
        ST_IMMOBILE   = 3'd7
    } t_status;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [DW-1:0] DIR_PX = 3'd0;
    localparam logic [DW-1:0] DIR_MX = 3'd1;
    localparam logic [DW-1:0] DIR_PY = 3'd2;
    localparam logic [DW-1:0] DIR_MY = 3'd3;
    localparam logic [DW-1:0] DIR_PZ = 3'd4;
    localparam logic [DW-1:0] DIR_MZ = 3'd5;

    localparam logic [1:0] CFG_REACT_A = 2'd0;
    localparam logic [1:0] CFG_REACT_B = 2'd1;
    localparam logic [1:0] CFG_PRODUCT = 2'd2;

    localparam logic [TW-1:0] RST_REACT_A = 2'd1;
    localparam logic [TW-1:0] RST_REACT_B = 2'd2;
    localparam logic [TW-1:0] RST_PRODUCT = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/lpw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lpw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/lattice_particle_walk_step.sv -----
// Top level of the lattice particle walk: 3D occupancy grid with exclusion.
// Depends on lpw_pkg and lpw_ram.
//
//  channel   dir   handshake                 payload
//  -------   ---   -----------------------   ----------------------------------------
//  command   in    i_in_valid / o_in_stall   cmd, pos_x/y/z, direction, mol_type, mobile
//  result    out   o_out_valid / i_out_stall new_x/y/z, mover_type, target_type, status
//  config    in    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A place command goes from acceptance through READ, EVAL1 and DONE; a step
// adds EVAL2 and WR2 as needed, set by the cell memory's single read and single write port:
// the mover cell is read, then the target cell, then up to two writes follow.
// After reset a clearing pass writes every cell empty, GRID_X*GRID_Y*GRID_Z
// cells (65536 at the default size); no command word is taken meanwhile.
// Configuration writes are taken in any cycle. A finished result waits in the
// output register while the next command is accepted and worked on; the block
// only holds in its final state if the previous result has not been taken.
`default_nettype none
module lattice_particle_walk_step #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [lpw_pkg::TW-1:0]  i_cfg_data,
    // command channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_cmd,
    input  wire logic [lpw_pkg::XW-1:0]  i_pos_x,
    input  wire logic [lpw_pkg::YW-1:0]  i_pos_y,
    input  wire logic [lpw_pkg::ZW-1:0]  i_pos_z,
    input  wire logic [lpw_pkg::DW-1:0]  i_direction,
    input  wire logic [lpw_pkg::TW-1:0]  i_mol_type,
    input  wire logic                    i_mobile,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [lpw_pkg::XW-1:0]       o_new_x,
    output logic [lpw_pkg::YW-1:0]       o_new_y,
    output logic [lpw_pkg::ZW-1:0]       o_new_z,
    output logic [lpw_pkg::TW-1:0]       o_mover_type,
    output logic [lpw_pkg::TW-1:0]       o_target_type,
    output logic [lpw_pkg::SW-1:0]       o_status
);

    localparam int CW    = lpw_pkg::CW;
    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int CELLW = $bits(lpw_pkg::t_cell);

    // Capsule geometry: a cylinder along x with a spherical cap at each end.
    localparam logic signed [CW-1:0]   CX  = CW'(GRID_X / 2);
    localparam logic signed [CW-1:0]   CY  = CW'(GRID_Y / 2);
    localparam logic signed [CW-1:0]   CZ  = CW'(GRID_Z / 2);
    localparam logic signed [CW-1:0]   LEN = CW'(GRID_X / 2 - GRID_Y / 2 - 1);
    localparam logic signed [CW-1:0]   CA  = CW'(GRID_X / 2 - (GRID_X / 2 - GRID_Y / 2 - 1));
    localparam logic signed [CW-1:0]   CB  = CW'(GRID_X / 2 + (GRID_X / 2 - GRID_Y / 2 - 1));
    localparam logic [2*CW:0]          R2  = (2*CW+1)'((GRID_Y / 2 - 1) * (GRID_Y / 2 - 1));
    localparam logic signed [CW-1:0]   GXS = CW'(GRID_X);
    localparam logic signed [CW-1:0]   GYS = CW'(GRID_Y);
    localparam logic signed [CW-1:0]   GZS = CW'(GRID_Z);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EVAL1 = 7'b0001000,
        S_EVAL2 = 7'b0010000,
        S_WR2   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    function automatic logic [AW-1:0] f_index(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
        logic [31:0] s;
        s = (32'(z) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_X) + 32'(x);
        return s[AW-1:0];
    endfunction

    function automatic logic [2*CW-1:0] f_sq(input logic signed [CW-1:0] a);
        logic signed [2*CW-1:0] p;
        p = (2*CW)'(a) * (2*CW)'(a);
        return $unsigned(p);
    endfunction

    function automatic logic f_in_grid(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] z);
        return (x >= 0) && (x < GXS) && (y >= 0) && (y < GYS) && (z >= 0) && (z < GZS);
    endfunction

    // Control state.
    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic                   r_out_valid, n_out_valid;
    logic [lpw_pkg::TW-1:0] r_react_a, r_react_b, r_product;

    // Command word and per-command working registers.
    logic                   r_cmd, n_cmd;
    logic [lpw_pkg::XW-1:0] r_x, n_x;
    logic [lpw_pkg::YW-1:0] r_y, n_y;
    logic [lpw_pkg::ZW-1:0] r_z, n_z;
    logic [lpw_pkg::DW-1:0] r_dir, n_dir;
    logic [lpw_pkg::TW-1:0] r_mtype, n_mtype;
    logic                   r_mob, n_mob;
    logic [AW-1:0]          r_sidx, n_sidx;
    logic [AW-1:0]          r_tidx, n_tidx;
    logic signed [CW-1:0]   r_tx, n_tx, r_ty, n_ty, r_tz, n_tz;
    logic                   r_src_grid, n_src_grid;
    logic                   r_tgt_ok, n_tgt_ok;
    logic [2*CW-1:0]        r_sq_a, n_sq_a, r_sq_b, n_sq_b;
    logic [2*CW:0]          r_sq_yz, n_sq_yz;
    logic                   r_adx_lt, n_adx_lt;
    lpw_pkg::t_cell         r_cell, n_cell;

    // Pending result and output register.
    logic [lpw_pkg::XW-1:0] r_res_x, n_res_x, r_o_x, n_o_x;
    logic [lpw_pkg::YW-1:0] r_res_y, n_res_y, r_o_y, n_o_y;
    logic [lpw_pkg::ZW-1:0] r_res_z, n_res_z, r_o_z, n_o_z;
    logic [lpw_pkg::TW-1:0] r_res_mover, n_res_mover, r_o_mover, n_o_mover;
    logic [lpw_pkg::TW-1:0] r_res_target, n_res_target, r_o_target, n_o_target;
    lpw_pkg::t_status       r_res_status, n_res_status, r_o_status, n_o_status;

    // Memory port signals.
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    lpw_pkg::t_cell         ram_wdata, ram_rdata;
    logic [CELLW-1:0]       ram_rdata_bits;

    // Combinational helpers.
    logic signed [CW-1:0]   sx, sy, sz, tx, ty, tz, px, py, pz, dx, adx;
    logic                   dir_ok, capsule;
    logic [AW-1:0]          src_idx;

    lpw_ram #(
        .WIDTH (CELLW),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    assign ram_rdata = lpw_pkg::t_cell'(ram_rdata_bits);

    assign sx = $signed({{(CW-lpw_pkg::XW){1'b0}}, r_x});
    assign sy = $signed({{(CW-lpw_pkg::YW){1'b0}}, r_y});
    assign sz = $signed({{(CW-lpw_pkg::ZW){1'b0}}, r_z});
    assign src_idx = f_index(sx, sy, sz);

    // Neighbor cell of the step; codes six and seven name no direction.
    always_comb begin
        tx = sx;
        ty = sy;
        tz = sz;
        dir_ok = 1'b1;
        case (r_dir)
            lpw_pkg::DIR_PX: tx = sx + CW'(1);
            lpw_pkg::DIR_MX: tx = sx - CW'(1);
            lpw_pkg::DIR_PY: ty = sy + CW'(1);
            lpw_pkg::DIR_MY: ty = sy - CW'(1);
            lpw_pkg::DIR_PZ: tz = sz + CW'(1);
            lpw_pkg::DIR_MZ: tz = sz - CW'(1);
            default: dir_ok = 1'b0;
        endcase
    end

    // The capsule is tested on the placed cell or on the step's neighbor.
    // Squares are registered here and compared in the next state.
    assign px  = (r_cmd == lpw_pkg::CMD_STEP) ? tx : sx;
    assign py  = (r_cmd == lpw_pkg::CMD_STEP) ? ty : sy;
    assign pz  = (r_cmd == lpw_pkg::CMD_STEP) ? tz : sz;
    assign dx  = px - CX;
    assign adx = dx[CW-1] ? -dx : dx;

    assign capsule = (r_adx_lt && (r_sq_yz <= R2))
                  || (({1'b0, r_sq_a} + r_sq_yz) <= R2)
                  || (({1'b0, r_sq_b} + r_sq_yz) <= R2);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_dir        = r_dir;
        n_mtype      = r_mtype;
        n_mob        = r_mob;
        n_sidx       = r_sidx;
        n_tidx       = r_tidx;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_tz         = r_tz;
        n_src_grid   = r_src_grid;
        n_tgt_ok     = r_tgt_ok;
        n_sq_a       = r_sq_a;
        n_sq_b       = r_sq_b;
        n_sq_yz      = r_sq_yz;
        n_adx_lt     = r_adx_lt;
        n_cell       = r_cell;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_z      = r_res_z;
        n_res_mover  = r_res_mover;
        n_res_target = r_res_target;
        n_res_status = r_res_status;
        n_o_x        = r_o_x;
        n_o_y        = r_o_y;
        n_o_z        = r_o_z;
        n_o_mover    = r_o_mover;
        n_o_target   = r_o_target;
        n_o_status   = r_o_status;
        ram_we       = 1'b0;
        ram_waddr    = r_sidx;
        ram_wdata    = '0;
        ram_raddr    = (r_state == S_EVAL1) ? r_tidx : src_idx;

        // The output register empties when its word is taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_x     = i_pos_x;
                    n_y     = i_pos_y;
                    n_z     = i_pos_z;
                    n_dir   = i_direction;
                    n_mtype = i_mol_type;
                    n_mob   = i_mobile;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // Mover cell is read; neighbor and capsule terms are registered.
                n_sidx     = src_idx;
                n_tidx     = f_index(tx, ty, tz);
                n_tx       = tx;
                n_ty       = ty;
                n_tz       = tz;
                n_src_grid = f_in_grid(sx, sy, sz);
                n_tgt_ok   = dir_ok && f_in_grid(tx, ty, tz);
                n_sq_a     = f_sq(px - CA);
                n_sq_b     = f_sq(px - CB);
                n_sq_yz    = {1'b0, f_sq(py - CY)} + {1'b0, f_sq(pz - CZ)};
                n_adx_lt   = adx < LEN;
                n_state    = S_EVAL1;
            end
            S_EVAL1: begin
                n_res_x      = r_x;
                n_res_y      = r_y;
                n_res_z      = r_z;
                n_res_target = '0;
                n_state      = S_DONE;
                n_cell       = ram_rdata;
                if (r_cmd == lpw_pkg::CMD_PLACE) begin
                    n_res_mover = r_mtype;
                    if (!r_src_grid || !capsule) begin
                        n_res_status = lpw_pkg::ST_REJECTED;
                    end else if (ram_rdata.occ) begin
                        n_res_target = ram_rdata.typ;
                        n_res_status = lpw_pkg::ST_REJECTED;
                    end else begin
                        ram_we       = 1'b1;
                        ram_wdata    = '{occ: 1'b1, mob: r_mob, typ: r_mtype};
                        n_res_status = lpw_pkg::ST_PLACED;
                    end
                end else if (!r_src_grid || !ram_rdata.occ) begin
                    n_res_mover  = '0;
                    n_res_status = lpw_pkg::ST_EMPTY;
                end else begin
                    n_res_mover = ram_rdata.typ;
                    if (!ram_rdata.mob) begin
                        n_res_status = lpw_pkg::ST_IMMOBILE;
                    end else if (!r_tgt_ok || !capsule) begin
                        n_res_status = lpw_pkg::ST_EDGE_BLOCK;
                    end else begin
                        // Neighbor cell is being read this cycle.
                        n_state = S_EVAL2;
                    end
                end
            end
            S_EVAL2: begin
                n_state = S_DONE;
                if (ram_rdata.occ) begin
                    n_res_target = ram_rdata.typ;
                    if (r_cell.typ == r_react_a && ram_rdata.typ == r_react_b) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_tidx;
                        ram_wdata    = '{occ: ram_rdata.occ, mob: ram_rdata.mob,
                                         typ: r_product};
                        n_res_target = r_product;
                        n_res_status = lpw_pkg::ST_REACTED;
                    end else if (r_cell.typ == r_react_b && ram_rdata.typ == r_react_a) begin
                        ram_we       = 1'b1;
                        ram_wdata    = '{occ: r_cell.occ, mob: r_cell.mob, typ: r_product};
                        n_res_mover  = r_product;
                        n_res_status = lpw_pkg::ST_REACTED;
                    end else begin
                        n_res_status = lpw_pkg::ST_PART_BLOCK;
                    end
                end else begin
                    // Move: copy the mover into the neighbor, then empty its old cell.
                    ram_we       = 1'b1;
                    ram_waddr    = r_tidx;
                    ram_wdata    = r_cell;
                    n_res_x      = r_tx[lpw_pkg::XW-1:0];
                    n_res_y      = r_ty[lpw_pkg::YW-1:0];
                    n_res_z      = r_tz[lpw_pkg::ZW-1:0];
                    n_res_status = lpw_pkg::ST_MOVED;
                    n_state      = S_WR2;
                end
            end
            S_WR2: begin
                ram_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_x       = r_res_x;
                    n_o_y       = r_res_y;
                    n_o_z       = r_res_z;
                    n_o_mover   = r_res_mover;
                    n_o_target  = r_res_target;
                    n_o_status  = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_react_a <= lpw_pkg::RST_REACT_A;
            r_react_b <= lpw_pkg::RST_REACT_B;
            r_product <= lpw_pkg::RST_PRODUCT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpw_pkg::CFG_REACT_A: r_react_a <= i_cfg_data;
                lpw_pkg::CFG_REACT_B: r_react_b <= i_cfg_data;
                lpw_pkg::CFG_PRODUCT: r_product <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_x          <= n_x;
        r_y          <= n_y;
        r_z          <= n_z;
        r_dir        <= n_dir;
        r_mtype      <= n_mtype;
        r_mob        <= n_mob;
        r_sidx       <= n_sidx;
        r_tidx       <= n_tidx;
        r_tx         <= n_tx;
        r_ty         <= n_ty;
        r_tz         <= n_tz;
        r_src_grid   <= n_src_grid;
        r_tgt_ok     <= n_tgt_ok;
        r_sq_a       <= n_sq_a;
        r_sq_b       <= n_sq_b;
        r_sq_yz      <= n_sq_yz;
        r_adx_lt     <= n_adx_lt;
        r_cell       <= n_cell;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_z      <= n_res_z;
        r_res_mover  <= n_res_mover;
        r_res_target <= n_res_target;
        r_res_status <= n_res_status;
        r_o_x        <= n_o_x;
        r_o_y        <= n_o_y;
        r_o_z        <= n_o_z;
        r_o_mover    <= n_o_mover;
        r_o_target   <= n_o_target;
        r_o_status   <= n_o_status;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_new_x       = r_o_x;
    assign o_new_y       = r_o_y;
    assign o_new_z       = r_o_z;
    assign o_mover_type  = r_o_mover;
    assign o_target_type = r_o_target;
    assign o_status      = r_o_status;

endmodule
`default_nettype wire

// ----- rtl/lpw_checker.sv -----
// Port-level checker for lattice_particle_walk_step, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none
module lpw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [5:0] o_new_x,
    input wire logic [2:0] o_status
);

    // The clearing pass keeps commands out right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("command accepted during clearing pass");

    // One command at a time: an accepted word closes the command channel.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command taken while one is in flight");

    // A waiting result is neither dropped nor changed.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_new_x))
        else $error("stalled result word changed or vanished");

endmodule

bind lattice_particle_walk_step lpw_checker u_lpw_checker (.*);
`default_nettype wire
